/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the message FIFO bank.
// Requires clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/mfb_pkg.sv */
// Package for the message FIFO bank: item structs, opcode and status codes,
// default sizes. No dependencies.
package mfb_pkg;

    localparam int NUM_QUEUES_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int WORD_BITS_DEF   = 16;

    localparam int HANDLE_BITS = 4;
    localparam int VALUE_BITS  = 16;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_NONE_LEFT  = 2'd2,
        ST_BAD_HANDLE = 2'd3
    } status_t;

    typedef struct packed {
        opcode_t                        opcode;
        logic [HANDLE_BITS-1:0]         queue_handle;
        logic signed [VALUE_BITS-1:0]   write_value;
    } cmd_t;

    typedef struct packed {
        status_t                        status;
        logic [HANDLE_BITS-1:0]         new_handle;
        logic signed [VALUE_BITS-1:0]   read_value;
    } rsp_t;

endpackage

/* rtl/core/mfb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mfb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/message_fifo_bank.sv */
// Message FIFO bank top level: command decode, per-queue pointers and counts,
// result register. Depends on mfb_pkg, mfb_ram and assert_macros.svh.
//
// Usage:
//   An item (cmd: opcode, queue_handle, write_value) is taken at a rising edge
//   where start is high and busy is low. busy stays low, so one item can be
//   given every cycle. Allocate returns the next free queue's handle (1 up);
//   write appends a word to the named queue (dropped when full); read pops the
//   oldest word or reports the queue empty.
//   Each item gives exactly one result on rsp, marked by done for one cycle.
//   An item is held in the input register; done and rsp come from the result
//   register and the RAM read register. Throughput is one item per
//   cycle, set by the storage RAM taking one access per cycle with a
//   registered read port.
//   Results come out in item order; the receiver cannot stall them.
//   Reset (rst_n low) frees every queue and clears all counts and pointers.
//   Storage contents are not cleared; no read can reach an unwritten word.
`include "assert_macros.svh"

module message_fifo_bank
    import mfb_pkg::*;
#(
    parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic done,
    output rsp_t rsp
);

    localparam int UW   = $clog2(NUM_QUEUES + 1);
    localparam int QW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int AW   = $clog2(NUM_QUEUES * QUEUE_DEPTH);
    localparam int CMPW = (UW > HANDLE_BITS) ? UW : HANDLE_BITS;

    // input register
    logic           in_vld_reg;
    cmd_t           in_reg;

    // per-queue state
    logic [CW-1:0]  cnt_reg [NUM_QUEUES];
    logic [PW-1:0]  wp_reg  [NUM_QUEUES];
    logic [PW-1:0]  rp_reg  [NUM_QUEUES];
    logic [UW-1:0]  in_use_reg;
    logic [UW-1:0]  in_use_next;

    // result register
    logic                   out_vld_reg;
    status_t                st_reg;
    status_t                st_next;
    logic [HANDLE_BITS-1:0] nh_reg;
    logic [HANDLE_BITS-1:0] nh_next;
    logic                   hit_reg;
    logic                   hit_next;

    // decode
    logic [QW-1:0]  q;
    logic           handle_ok;
    logic           alloc_ok;
    logic [CW-1:0]  cur_cnt;
    logic [PW-1:0]  cur_wp;
    logic [PW-1:0]  cur_rp;
    logic           upd_en;
    logic [QW-1:0]  upd_idx;
    logic [CW-1:0]  cnt_next;
    logic [PW-1:0]  wp_next;
    logic [PW-1:0]  rp_next;

    // storage
    logic                   ram_we;
    logic                   ram_re;
    logic [AW-1:0]          ram_waddr;
    logic [AW-1:0]          ram_raddr;
    logic [WORD_BITS-1:0]   ram_wdata;
    logic [WORD_BITS-1:0]   ram_rdata;

    assign busy = 1'b0;

    assign q         = QW'(CMPW'(in_reg.queue_handle) - CMPW'(1));
    assign handle_ok = (in_reg.queue_handle != '0)
                    && (CMPW'(in_reg.queue_handle) <= CMPW'(in_use_reg));
    assign alloc_ok  = (in_use_reg < UW'(NUM_QUEUES));
    assign cur_cnt   = cnt_reg[q];
    assign cur_wp    = wp_reg[q];
    assign cur_rp    = rp_reg[q];

    // flat storage address: queue * depth + pointer, below the RAM depth for a valid handle
    assign ram_waddr = AW'(q) * AW'(QUEUE_DEPTH) + AW'(cur_wp);
    assign ram_raddr = AW'(q) * AW'(QUEUE_DEPTH) + AW'(cur_rp);
    assign ram_wdata = WORD_BITS'(in_reg.write_value);

    always_comb
    begin
        in_use_next = in_use_reg;
        st_next     = ST_OK;
        nh_next     = '0;
        hit_next    = 1'b0;
        upd_en      = 1'b0;
        upd_idx     = q;
        cnt_next    = cur_cnt;
        wp_next     = cur_wp;
        rp_next     = cur_rp;
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        if (in_vld_reg)
        begin
            case (in_reg.opcode)
                OP_ALLOC:
                begin
                    if (alloc_ok)
                    begin
                        upd_en      = 1'b1;
                        upd_idx     = QW'(in_use_reg);
                        cnt_next    = '0;
                        wp_next     = '0;
                        rp_next     = '0;
                        in_use_next = in_use_reg + UW'(1);
                        nh_next     = HANDLE_BITS'(in_use_reg + UW'(1));
                    end
                    else
                    begin
                        st_next = ST_NONE_LEFT;
                    end
                end
                OP_WRITE:
                begin
                    if (!handle_ok)
                    begin
                        st_next = ST_BAD_HANDLE;
                    end
                    else if (cur_cnt < CW'(QUEUE_DEPTH))
                    begin
                        // a full queue drops the word but still reports ok
                        ram_we   = 1'b1;
                        upd_en   = 1'b1;
                        cnt_next = cur_cnt + CW'(1);
                        wp_next  = (cur_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : cur_wp + PW'(1);
                    end
                end
                OP_READ:
                begin
                    if (!handle_ok)
                    begin
                        st_next = ST_BAD_HANDLE;
                    end
                    else if (cur_cnt == '0)
                    begin
                        st_next = ST_EMPTY;
                    end
                    else
                    begin
                        ram_re   = 1'b1;
                        hit_next = 1'b1;
                        upd_en   = 1'b1;
                        cnt_next = cur_cnt - CW'(1);
                        rp_next  = (cur_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : cur_rp + PW'(1);
                    end
                end
                default:
                begin
                    st_next = ST_BAD_HANDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            in_use_reg  <= '0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                cnt_reg[i] <= '0;
                wp_reg[i]  <= '0;
                rp_reg[i]  <= '0;
            end
        end
        else
        begin
            in_vld_reg  <= start && !busy;
            out_vld_reg <= in_vld_reg;
            in_use_reg  <= in_use_next;
            if (upd_en)
            begin
                cnt_reg[upd_idx] <= cnt_next;
                wp_reg[upd_idx]  <= wp_next;
                rp_reg[upd_idx]  <= rp_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_reg <= cmd;
        end
        st_reg  <= st_next;
        nh_reg  <= nh_next;
        hit_reg <= hit_next;
    end

    mfb_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_QUEUES * QUEUE_DEPTH)
    ) u_storage (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign done            = out_vld_reg;
    assign rsp.status      = st_reg;
    assign rsp.new_handle  = nh_reg;
    assign rsp.read_value  = hit_reg ? VALUE_BITS'($signed(ram_rdata)) : '0;

    `ASSERT_NEXT(a_item_gives_result, in_vld_reg, done, "item gave no result")
    `ASSERT_SAME(a_in_use_bound, 1'b1, in_use_reg <= UW'(NUM_QUEUES), "bank overrun")
    `ASSERT_SAME(a_count_bound, in_vld_reg && handle_ok, cur_cnt <= CW'(QUEUE_DEPTH), "count > depth")
    `ASSERT_SAME(a_value_only_on_pop, done && (rsp.read_value != '0), hit_reg && (rsp.status == ST_OK), "stray read value")

endmodule

/* tb/message_fifo_bank_tb.sv */
// Self-checking testbench for message_fifo_bank: directed and random command items,
// random idle gaps, scoreboard class that predicts every response in order.
// Depends on mfb_pkg and the message_fifo_bank RTL.
module message_fifo_bank_tb;
    import mfb_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         ITEM_TOTAL = 1450;
    localparam int         DRAIN_MAX  = 500;

    class fifo_bank_scoreboard;
        logic signed [VALUE_BITS-1:0] words [NUM_QUEUES_DEF][QUEUE_DEPTH_DEF];
        int unsigned fill_level [NUM_QUEUES_DEF];
        int unsigned head [NUM_QUEUES_DEF];
        int unsigned tail [NUM_QUEUES_DEF];
        int unsigned queues_taken;
        rsp_t        expected_rsp [$];
        int unsigned mismatches;

        function new();
            queues_taken = 0;
            mismatches   = 0;
            foreach (fill_level[i])
            begin
                fill_level[i] = 0;
                head[i]       = 0;
                tail[i]       = 0;
            end
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR @%0t: %s", $time, what);
        endfunction

        function int unsigned pending();
            return expected_rsp.size();
        endfunction

        // Work out the response to one accepted item and queue it.
        function void note_item(cmd_t c);
            rsp_t        r;
            int unsigned q;
            r.status     = ST_OK;
            r.new_handle = '0;
            r.read_value = '0;
            if (c.opcode == OP_ALLOC)
            begin
                if (queues_taken < NUM_QUEUES_DEF)
                begin
                    q             = queues_taken;
                    fill_level[q] = 0;
                    head[q]       = 0;
                    tail[q]       = 0;
                    queues_taken++;
                    r.new_handle  = HANDLE_BITS'(queues_taken);
                end
                else
                    r.status = ST_NONE_LEFT;
            end
            else if (c.opcode == OP_UNUSED || c.queue_handle == 0
                     || c.queue_handle > queues_taken)
                r.status = ST_BAD_HANDLE;
            else
            begin
                q = c.queue_handle - 1;
                if (c.opcode == OP_WRITE)
                begin
                    // full queue: word dropped, status still ok
                    if (fill_level[q] < QUEUE_DEPTH_DEF)
                    begin
                        // word width equals the field width, so no extension
                        words[q][tail[q]] = c.write_value;
                        tail[q] = (tail[q] + 1) % QUEUE_DEPTH_DEF;
                        fill_level[q]++;
                    end
                end
                else if (fill_level[q] == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.read_value = words[q][head[q]];
                    head[q] = (head[q] + 1) % QUEUE_DEPTH_DEF;
                    fill_level[q]--;
                end
            end
            expected_rsp.push_back(r);
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (expected_rsp.size() == 0)
            begin
                flag($sformatf("response with no item pending: status=%0d handle=%0d value=%0d",
                               got.status, got.new_handle, got.read_value));
                return;
            end
            want = expected_rsp.pop_front();
            if (got.status !== want.status || got.new_handle !== want.new_handle
                || got.read_value !== want.read_value)
                flag($sformatf({"exp status=%0d handle=%0d value=%0d, ",
                                "got status=%0d handle=%0d value=%0d"},
                               want.status, want.new_handle, want.read_value,
                               got.status, got.new_handle, got.read_value));
        endfunction

        function void flush_leftover();
            rsp_t want;
            while (expected_rsp.size() != 0)
            begin
                want = expected_rsp.pop_front();
                flag($sformatf("response never came: status=%0d handle=%0d value=%0d",
                               want.status, want.new_handle, want.read_value));
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    cmd_t cmd;
    rsp_t rsp;

    fifo_bank_scoreboard sb;
    int unsigned items_sent;
    int unsigned allocs_sent;
    bit          quiet_stretch;

    message_fifo_bank u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(rsp);
            if (start && !busy)
                sb.note_item(cmd);
        end
    end

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int unsigned live_queues();
        return (allocs_sent > NUM_QUEUES_DEF) ? NUM_QUEUES_DEF : allocs_sent;
    endfunction

    function automatic logic [3:0] pick_live_handle();
        return 4'($urandom_range(1, live_queues()));
    endfunction

    // zero, or any handle above the allocated ones
    function automatic logic [3:0] pick_dead_handle();
        if ($urandom_range(0, 3) == 0)
            return 4'd0;
        return 4'($urandom_range(live_queues() + 1, 15));
    endfunction

    task automatic send_item(logic [1:0] op, logic [3:0] handle, logic [15:0] value);
        cmd_t c;
        int   gap;
        // an idle gap before about one item in 25, outside the quiet stretch: roughly 10% idle
        if (!quiet_stretch && $urandom_range(0, 99) < 4)
        begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            cmd   <= cmd_t'($urandom);
            repeat (gap) @(posedge clk);
        end
        c.opcode       = opcode_t'(op);
        c.queue_handle = handle;
        c.write_value  = value;
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
        items_sent++;
        if (op == OP_ALLOC)
            allocs_sent++;
    endtask

    // hold off new items until every response is back (bounded)
    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (sb.pending() != 0 && guard < DRAIN_MAX);
    endtask

    initial
    begin
        #2_000_000;
        $display("ERROR: run timed out");
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int  kind;
        int  n;
        bit  paused;
        logic [3:0] h;
        sb            = new();
        items_sent    = 0;
        allocs_sent   = 0;
        quiet_stretch = 1'b0;
        paused        = 1'b0;
        rst_n <= 1'b0;
        start <= 1'b0;
        cmd   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: bad handles before any queue exists, extremes, empty read
        send_item(OP_WRITE, 4'd1, 16'h1234);
        send_item(OP_READ, 4'd0, 16'h0000);
        send_item(OP_UNUSED, 4'd1, 16'hFFFF);
        send_item(OP_ALLOC, 4'hF, 16'hA5A5);
        send_item(OP_WRITE, 4'd1, 16'h7FFF);
        send_item(OP_WRITE, 4'd1, 16'h8000);
        send_item(OP_WRITE, 4'd1, 16'hFFFF);
        send_item(OP_WRITE, 4'd1, 16'h0000);
        repeat (5) send_item(OP_READ, 4'd1, 16'h0000);
        send_item(OP_WRITE, 4'd2, 16'h1111);
        send_item(OP_READ, 4'hF, 16'h0000);
        send_item(OP_ALLOC, 4'h0, 16'h0000);
        send_item(OP_WRITE, 4'd2, 16'h5A5A);
        send_item(OP_WRITE, 4'd0, 16'h0001);
        send_item(OP_UNUSED, 4'd2, 16'h0002);
        send_item(OP_READ, 4'd2, 16'h0000);
        send_item(OP_READ, 4'd2, 16'h0000);
        drain();

        while (items_sent < ITEM_TOTAL)
        begin
            quiet_stretch = (items_sent >= 600 && items_sent < 900);
            if (!paused && items_sent >= 1000)
            begin
                drain();
                paused = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 8)
                send_item(OP_ALLOC, 4'($urandom), pick_word());
            else if (kind < 50)
            begin
                h = pick_live_handle();
                n = $urandom_range(1, 24);
                repeat (n)
                    send_item(($urandom_range(0, 99) < 55) ? OP_WRITE : OP_READ, h,
                              pick_word());
            end
            else if (kind < 65)
            begin
                // fill one queue to or past full, then read it to or past empty
                h = pick_live_handle();
                n = QUEUE_DEPTH_DEF + $urandom_range(0, 3);
                repeat (n) send_item(OP_WRITE, h, pick_word());
                n = QUEUE_DEPTH_DEF + $urandom_range(0, 2);
                repeat (n) send_item(OP_READ, h, 16'($urandom));
            end
            else if (kind < 80)
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    send_item($urandom_range(0, 1) ? OP_WRITE : OP_READ, pick_dead_handle(),
                              pick_word());
            end
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    send_item(2'($urandom_range(0, 3)), 4'($urandom), 16'($urandom));
            end
        end

        drain();
        repeat (6) @(posedge clk);
        sb.flush_leftover();
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
